// ----- design/difference_pseudocolor_mapper_defines.svh -----
// Assertion macros shared by the difference pseudocolour mapper RTL
`ifndef DIFFERENCE_PSEUDOCOLOR_MAPPER_DEFINES_SVH
`define DIFFERENCE_PSEUDOCOLOR_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpm assertion failed");

`endif

// ----- design/dpm_pkg.sv -----
// Shared widths, register indexes and coefficient helpers of the pseudocolour mapper
package dpm_pkg;

  localparam int CHAN_W    = 8;
  localparam int ENTRY_W   = 3 * CHAN_W;
  localparam int GREY_W    = 8;
  localparam int SIZE_W    = 9;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YIQ_ENABLE   = 4'd1;

  // Item kinds
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  // YIQ to BGR coefficients, in thousandths
  localparam int MILLI_B_I = 1106;
  localparam int MILLI_B_Q = 1703;
  localparam int MILLI_G_I = 272;
  localparam int MILLI_G_Q = 647;
  localparam int MILLI_R_I = 956;
  localparam int MILLI_R_Q = 621;

  localparam int CHROMA_BIAS = 128;
  localparam int CHAN_MAX    = 255;

  // Round a coefficient in thousandths to a fixed-point integer
  function automatic int qcoef(input int milli, input int frac);
    longint scaled;
    scaled = (longint'(milli) <<< frac) + 64'sd500;
    return int'(scaled / 1000);
  endfunction

endpackage

// ----- design/difference_pseudocolor_mapper.sv -----
// Top level of the difference pseudocolour mapper
//
// Input words arrive on a valid/ready channel. A palette word (kind 0) writes
// one 24-bit colour table entry and returns nothing; a pixel word (kind 1)
// carries two grey samples and returns one three-channel word on the output
// valid/ready channel. The table index is floor(size*|a-b|/255), held at
// size-1 for a full-scale difference; with YIQ mode on the entry is turned
// into BGR in fixed point, otherwise it is passed through.
// Configuration is a plain write port: index 0 sets the palette size,
// index 1 the YIQ mode; write only while no pixel is in flight.
// A pixel word passes the palette RAM read register, the product stage and
// the output register in turn. Throughput: one word per cycle while the output
// is not stalled, set by the single palette RAM read port, read once per pixel.
// Reset clears the pipeline valids and the configuration (size 1, YIQ off);
// the palette contents stay undefined until written and no clearing pass runs.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops.
`include "difference_pseudocolor_mapper_defines.svh"

module difference_pseudocolor_mapper import dpm_pkg::*; #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [GREY_W-1:0]    grey_first_i,
  input  logic [GREY_W-1:0]    grey_second_i,
  input  logic [CHAN_W-1:0]    entry_index_i,
  input  logic [CHAN_W-1:0]    entry_first_i,
  input  logic [CHAN_W-1:0]    entry_second_i,
  input  logic [CHAN_W-1:0]    entry_third_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHAN_W-1:0]    out_first_o,
  output logic [CHAN_W-1:0]    out_second_o,
  output logic [CHAN_W-1:0]    out_third_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [SIZE_W-1:0]  palette_size_q;
  logic               yiq_en_q;
  logic               adv;
  logic               accept;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               s1_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= SIZE_W'(1);
      yiq_en_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PALETTE_SIZE: palette_size_q <= cfg_data_i[SIZE_W-1:0];
        CFG_YIQ_ENABLE:   yiq_en_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output word is stuck
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Palette write, drop indexes beyond the table
  assign wr_en   = accept && (kind_i == KIND_PALETTE) &&
                   (int'(entry_index_i) < PALETTE_DEPTH);
  assign wr_addr = AW'(entry_index_i);

  dpm_index #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_index (
    .palette_size_i(palette_size_q),
    .grey_first_i  (grey_first_i),
    .grey_second_i (grey_second_i),
    .slot_o        (rd_addr)
  );

  assign rd_en = accept && (kind_i == KIND_PIXEL);

  dpm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i({entry_third_i, entry_second_i, entry_first_i}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Lookup stage valid, tracks the RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= rd_en;
    end
  end

  dpm_yiq #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_yiq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (s1_valid_q),
    .yiq_en_i    (yiq_en_q),
    .entry_i     (rd_data),
    .out_valid_o (out_valid_o),
    .out_first_o (out_first_o),
    .out_second_o(out_second_o),
    .out_third_o (out_third_o)
  );

  // A pixel word reaches the lookup stage on the next edge
  `DPM_ASSERT_NXT(a_pixel_enters, clk_i, rst_ni, accept && (kind_i == KIND_PIXEL), s1_valid_q)
  // A palette word never produces a lookup
  `DPM_ASSERT_NXT(a_palette_silent, clk_i, rst_ni, accept && (kind_i == KIND_PALETTE),
                  !s1_valid_q)
  // A stall freezes the lookup stage
  `DPM_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !adv, $stable(s1_valid_q) && $stable(rd_data))
  // Lookups stay inside the palette in use
  `DPM_ASSERT_IMP(a_slot_range, clk_i, rst_ni, rd_en,
                  (int'(rd_addr) < PALETTE_DEPTH) &&
                  ((int'(rd_addr) < int'(palette_size_q)) || (rd_addr == '0)))

endmodule

// ----- design/dpm_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module dpm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dpm_index.sv -----
// Palette slot selection from the absolute grey difference
module dpm_index import dpm_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic [SIZE_W-1:0]                palette_size_i,
  input  logic [GREY_W-1:0]                grey_first_i,
  input  logic [GREY_W-1:0]                grey_second_i,
  output logic [$clog2(PALETTE_DEPTH)-1:0] slot_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int PW = SIZE_W + GREY_W;

  logic [SIZE_W-1:0] size;
  logic [GREY_W-1:0] diff;
  logic [PW-1:0]     prod;
  logic [SIZE_W-1:0] quot_est;
  logic [SIZE_W:0]   rem;
  logic [SIZE_W-1:0] quot;
  logic [SIZE_W-1:0] slot;

  // Clamp the palette size to 1..depth
  always_comb begin
    if (palette_size_i == '0) begin
      size = SIZE_W'(1);
    end else if (int'(palette_size_i) > PALETTE_DEPTH) begin
      size = SIZE_W'(PALETTE_DEPTH);
    end else begin
      size = palette_size_i;
    end
  end

  // Absolute difference
  assign diff = (grey_first_i > grey_second_i) ? (grey_first_i - grey_second_i)
                                               : (grey_second_i - grey_first_i);

  // Divide size*diff by 255: estimate by 256, then correct by up to two
  always_comb begin
    prod     = PW'(size) * PW'(diff);
    quot_est = prod[PW-1:GREY_W];
    rem      = (SIZE_W+1)'(prod[GREY_W-1:0]) + (SIZE_W+1)'(quot_est);
    quot     = quot_est;
    if (rem >= (SIZE_W+1)'(CHAN_MAX)) begin
      quot = quot + SIZE_W'(1);
    end
    if (rem >= (SIZE_W+1)'(2 * CHAN_MAX)) begin
      quot = quot + SIZE_W'(1);
    end
  end

  // Clamp a full-scale difference to the last slot in use
  assign slot   = (quot > size - SIZE_W'(1)) ? (size - SIZE_W'(1)) : quot;
  assign slot_o = AW'(slot);

endmodule

// ----- design/dpm_yiq.sv -----
// Optional YIQ to BGR conversion stage and output register
module dpm_yiq import dpm_pkg::*; #(
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic               yiq_en_i,
  input  logic [ENTRY_W-1:0] entry_i,
  output logic               out_valid_o,
  output logic [CHAN_W-1:0]  out_first_o,
  output logic [CHAN_W-1:0]  out_second_o,
  output logic [CHAN_W-1:0]  out_third_o
);

  localparam int CW   = COEF_FRAC_BITS + 3;
  localparam int PW   = CW + CHAN_W + 1;
  localparam int ACCW = PW + 2;

  localparam logic signed [CW-1:0] K_BI = CW'(qcoef(MILLI_B_I, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_BQ = CW'(qcoef(MILLI_B_Q, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_GI = CW'(qcoef(MILLI_G_I, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_GQ = CW'(qcoef(MILLI_G_Q, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_RI = CW'(qcoef(MILLI_R_I, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_RQ = CW'(qcoef(MILLI_R_Q, COEF_FRAC_BITS));

  logic signed [CHAN_W:0]   chan_i;
  logic signed [CHAN_W:0]   chan_q;
  logic                     s2_valid_q;
  logic [ENTRY_W-1:0]       s2_entry_q;
  logic signed [PW-1:0]     p_bi_q, p_bq_q, p_gi_q, p_gq_q, p_ri_q, p_rq_q;
  logic signed [ACCW-1:0]   acc_y;
  logic signed [ACCW-1:0]   acc_b, acc_g, acc_r;
  logic [CHAN_W-1:0]        first_d, second_d, third_d;
  logic                     out_valid_q;
  logic [CHAN_W-1:0]        first_q, second_q, third_q;

  // Truncate to integer, saturate to the channel range
  function automatic logic [CHAN_W-1:0] sat_chan(input logic signed [ACCW-1:0] a);
    logic signed [ACCW-1:0] v;
    v = a >>> COEF_FRAC_BITS;
    if (a < 0) begin
      return '0;
    end else if (v > ACCW'(CHAN_MAX)) begin
      return CHAN_W'(CHAN_MAX);
    end else begin
      return v[CHAN_W-1:0];
    end
  endfunction

  // Remove the chroma bias
  assign chan_i = $signed({1'b0, entry_i[2*CHAN_W-1:CHAN_W]}) - (CHAN_W+1)'(CHROMA_BIAS);
  assign chan_q = $signed({1'b0, entry_i[3*CHAN_W-1:2*CHAN_W]}) - (CHAN_W+1)'(CHROMA_BIAS);

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_entry_q <= entry_i;
      p_bi_q     <= PW'(K_BI) * PW'(chan_i);
      p_bq_q     <= PW'(K_BQ) * PW'(chan_q);
      p_gi_q     <= PW'(K_GI) * PW'(chan_i);
      p_gq_q     <= PW'(K_GQ) * PW'(chan_q);
      p_ri_q     <= PW'(K_RI) * PW'(chan_i);
      p_rq_q     <= PW'(K_RQ) * PW'(chan_q);
    end
  end

  // Sum, saturate and select the pass-through entry
  always_comb begin
    acc_y = ACCW'($signed({1'b0, s2_entry_q[CHAN_W-1:0]})) <<< COEF_FRAC_BITS;
    acc_b = acc_y - ACCW'(p_bi_q) + ACCW'(p_bq_q);
    acc_g = acc_y - ACCW'(p_gi_q) - ACCW'(p_gq_q);
    acc_r = acc_y + ACCW'(p_ri_q) + ACCW'(p_rq_q);
    if (yiq_en_i) begin
      first_d  = sat_chan(acc_b);
      second_d = sat_chan(acc_g);
      third_d  = sat_chan(acc_r);
    end else begin
      first_d  = s2_entry_q[CHAN_W-1:0];
      second_d = s2_entry_q[2*CHAN_W-1:CHAN_W];
      third_d  = s2_entry_q[3*CHAN_W-1:2*CHAN_W];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = first_q;
  assign out_second_o = second_q;
  assign out_third_o  = third_q;

endmodule
